// ----- hw/rtl/lhm_pkg.sv -----
package lhm_pkg;

    // Field widths of the stream items
    localparam int KIND_W   = 2;
    localparam int KEY_W    = 16;
    localparam int ENTRY_W  = 8;
    localparam int STATUS_W = 2;

    // Operation codes
    localparam logic [KIND_W-1:0] OP_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] OP_LOOKUP = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    localparam logic [ENTRY_W-1:0] ENTRY_LIMIT_RST = 8'd160;
    localparam logic [ENTRY_W-1:0] ENTRY_NONE      = 8'hFF;

    // Result selection for the output register
    typedef enum logic [1:0] {
        RES_OK,
        RES_MISS,
        RES_FULL,
        RES_LOOKUP
    } t_res;

    // Controller -> datapath
    typedef struct packed {
        logic accept;      // latch input item
        logic hash_start;  // load mixed key into hash pipe
        logic use_rep;     // work on the relocated slot, not the item
        logic home_load;   // probe slot <= home, probe count <= 0
        logic probe_next;  // advance probe slot
        logic rd_scan;     // read at scan pointer instead of probe slot
        logic wr_key;      // store key (and value, with wr_val)
        logic wr_val;      // write value (zero unless wr_key)
        logic wr_at_scan;  // write at scan pointer instead of probe slot
        logic rep_load;    // capture read slot for relocation
        logic scan_init;   // scan <= probe slot + 1, scan count <= 0
        logic scan_next;   // advance scan pointer
        logic keep_val;    // keep read value for lookup result
        logic res_load;    // load output register
        t_res res;
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              ent_max;    // entry cannot be stored
        logic              val_zero;   // slot read is empty
        logic              key_eq;     // slot key equals working key
        logic              val_eq;     // slot value equals item entry + 1
        logic              cnt_last;   // probe has visited every slot
        logic              mcnt_full;  // relocation count exhausted
        logic              scan_last;  // scan pointer at last slot
        logic              out_free;   // output register can take a result
    } t_sts;

    // xorshift mix of a key, 16 bits wide
    function automatic logic [KEY_W-1:0] mix_key(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] h;
        h = k;
        h = h ^ (h >> 7);
        h = h ^ (h << 9);
        h = h ^ (h >> 8);
        return h;
    endfunction

endpackage

// ----- hw/rtl/lhm_dpath.sv -----
module lhm_dpath #(
    parameter int SLOT_COUNT = 512
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lhm_pkg::t_cmd               i_cmd,
    output lhm_pkg::t_sts               o_sts,
    input  logic [lhm_pkg::KIND_W-1:0]  i_kind,
    input  logic [lhm_pkg::KEY_W-1:0]   i_key,
    input  logic [lhm_pkg::ENTRY_W-1:0] i_entry,
    input  logic                        i_cfg_we,
    input  logic [lhm_pkg::ENTRY_W-1:0] i_cfg_wdata,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [lhm_pkg::STATUS_W-1:0] o_status,
    output logic [lhm_pkg::ENTRY_W-1:0] o_found
);
    import lhm_pkg::*;

    localparam int AW = $clog2(SLOT_COUNT);
    localparam int MW = $clog2(SLOT_COUNT + 1);
    localparam logic [AW-1:0] LAST = AW'(SLOT_COUNT - 1);
    localparam logic [MW-1:0] M_FULL = MW'(SLOT_COUNT);
    localparam logic [15:0] N16 = 16'(SLOT_COUNT);
    // floor(2^32 / N): quotient estimate is exact or one short
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / SLOT_COUNT);

    // item
    logic [KIND_W-1:0]  r_kind;
    logic [KEY_W-1:0]   r_key;
    logic [ENTRY_W-1:0] r_entry;
    // slot being relocated
    logic [KEY_W-1:0]   r_rep_key;
    logic [ENTRY_W-1:0] r_rep_val;
    // hash pipe
    logic [15:0] r_h;
    logic [47:0] r_prod;
    logic [15:0] r_qn;
    // pointers
    logic [AW-1:0] r_slot;
    logic [AW-1:0] r_cnt;
    logic [AW-1:0] r_scan;
    logic [MW-1:0] r_mcnt;
    // memories and read data
    logic [KEY_W-1:0]   r_keys [SLOT_COUNT];
    logic [ENTRY_W-1:0] r_vals [SLOT_COUNT];
    logic [KEY_W-1:0]   r_rd_key;
    logic [ENTRY_W-1:0] r_rd_val;
    logic [ENTRY_W-1:0] r_hit_val;
    logic [ENTRY_W-1:0] r_limit;
    logic               r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [ENTRY_W-1:0] r_found;

    logic [KEY_W-1:0]   cur_key;
    logic [ENTRY_W-1:0] item_val;
    logic [ENTRY_W-1:0] store_val;
    logic [31:0]        qn_full;
    logic [15:0]        rem;
    logic [15:0]        home;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      slot_inc;
    logic [AW-1:0]      scan_inc;

    assign cur_key   = i_cmd.use_rep ? r_rep_key : r_key;
    assign item_val  = r_entry + 8'd1;
    assign store_val = i_cmd.use_rep ? r_rep_val : item_val;
    assign qn_full   = 32'(r_prod[47:32]) * 32'(N16);
    assign rem       = r_h - r_qn;
    assign home      = (rem >= N16) ? (rem - N16) : rem;
    assign rd_addr   = i_cmd.rd_scan ? r_scan : r_slot;
    assign wr_addr   = i_cmd.wr_at_scan ? r_scan : r_slot;
    assign slot_inc  = (r_slot == LAST) ? '0 : r_slot + 1'b1;
    assign scan_inc  = (r_scan == LAST) ? '0 : r_scan + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind  <= i_kind;
            r_key   <= i_key;
            r_entry <= i_entry;
        end
        if (i_cmd.rep_load) begin
            r_rep_key <= r_rd_key;
            r_rep_val <= r_rd_val;
        end
        if (i_cmd.hash_start) begin
            r_h <= mix_key(cur_key);
        end
        r_prod <= 48'(r_h) * 48'(RECIP);
        r_qn   <= qn_full[15:0];
        if (i_cmd.home_load) begin
            r_slot <= AW'(home);
            r_cnt  <= '0;
        end else if (i_cmd.probe_next) begin
            r_slot <= slot_inc;
            r_cnt  <= r_cnt + 1'b1;
        end
        if (i_cmd.keep_val) begin
            r_hit_val <= r_rd_val;
        end
    end

    // slot store: one write and one read address per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_key) begin
            r_keys[wr_addr] <= cur_key;
        end
        if (i_cmd.wr_val) begin
            r_vals[wr_addr] <= i_cmd.wr_key ? store_val : '0;
        end
        r_rd_key <= r_keys[rd_addr];
        r_rd_val <= r_vals[rd_addr];
    end

    // scan pointer doubles as the clear sweep address after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan      <= '0;
            r_mcnt      <= '0;
            r_limit     <= ENTRY_LIMIT_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.scan_init) begin
                r_scan <= slot_inc;
                r_mcnt <= '0;
            end else if (i_cmd.scan_next) begin
                r_scan <= scan_inc;
                r_mcnt <= r_mcnt + 1'b1;
            end
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (i_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_found <= '0;
            case (i_cmd.res)
                RES_OK:   r_status <= ST_OK;
                RES_FULL: r_status <= ST_FULL;
                RES_LOOKUP: begin
                    if (r_hit_val != '0 && r_hit_val <= r_limit) begin
                        r_status <= ST_OK;
                        r_found  <= r_hit_val - 8'd1;
                    end else begin
                        r_status <= ST_MISS;
                    end
                end
                default:  r_status <= ST_MISS;
            endcase
        end
    end

    assign o_sts.kind      = r_kind;
    assign o_sts.ent_max   = (r_entry == ENTRY_NONE);
    assign o_sts.val_zero  = (r_rd_val == '0);
    assign o_sts.key_eq    = (r_rd_key == cur_key);
    assign o_sts.val_eq    = (r_rd_val == item_val);
    assign o_sts.cnt_last  = (r_cnt == LAST);
    assign o_sts.mcnt_full = (r_mcnt == M_FULL);
    assign o_sts.scan_last = (r_scan == LAST);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_found     = r_found;

endmodule

// ----- hw/rtl/lhm_ctrl.sv -----
module lhm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  lhm_pkg::t_sts i_sts,
    output lhm_pkg::t_cmd o_cmd
);
    import lhm_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_H0    = 4'd2;
    localparam logic [3:0] S_H1    = 4'd3;
    localparam logic [3:0] S_H2    = 4'd4;
    localparam logic [3:0] S_H3    = 4'd5;
    localparam logic [3:0] S_PRD   = 4'd6;
    localparam logic [3:0] S_PCK   = 4'd7;
    localparam logic [3:0] S_RRD   = 4'd8;
    localparam logic [3:0] S_RCK   = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;

    logic [3:0] r_state, n_state;
    logic       r_rep, n_rep;     // relocating a cluster slot
    t_res       r_res, n_res;
    logic       op_ok;

    assign op_ok = (i_sts.kind == OP_LOOKUP) ||
                   ((i_sts.kind inside {OP_INSERT, OP_REMOVE}) && !i_sts.ent_max);

    always_comb begin
        n_state    = r_state;
        n_rep      = r_rep;
        n_res      = r_res;
        o_cmd      = '0;
        o_cmd.res  = r_res;
        o_cmd.use_rep = r_rep;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.wr_val     = 1'b1;
                o_cmd.wr_at_scan = 1'b1;
                o_cmd.scan_next  = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_rep        = 1'b0;
                    n_state      = S_H0;
                end
            end
            S_H0: begin
                o_cmd.hash_start = 1'b1;
                if (!r_rep && !op_ok) begin
                    n_res   = RES_MISS;
                    n_state = S_FIN;
                end else begin
                    n_state = S_H1;
                end
            end
            S_H1: n_state = S_H2;
            S_H2: n_state = S_H3;
            S_H3: begin
                o_cmd.home_load = 1'b1;
                n_state         = S_PRD;
            end
            S_PRD: n_state = S_PCK;
            S_PCK: begin
                if (r_rep || i_sts.kind == OP_INSERT) begin
                    if (i_sts.val_zero || i_sts.key_eq) begin
                        o_cmd.wr_key = 1'b1;
                        o_cmd.wr_val = 1'b1;
                        if (r_rep) begin
                            o_cmd.scan_next = 1'b1;
                            n_state         = S_RRD;
                        end else begin
                            n_res   = RES_OK;
                            n_state = S_FIN;
                        end
                    end else if (i_sts.cnt_last) begin
                        if (r_rep) begin
                            o_cmd.scan_next = 1'b1;
                            n_state         = S_RRD;
                        end else begin
                            n_res   = RES_FULL;
                            n_state = S_FIN;
                        end
                    end else begin
                        o_cmd.probe_next = 1'b1;
                        n_state          = S_PRD;
                    end
                end else if (i_sts.val_zero) begin
                    n_res   = RES_MISS;
                    n_state = S_FIN;
                end else if (i_sts.key_eq) begin
                    if (i_sts.kind == OP_REMOVE) begin
                        if (i_sts.val_eq) begin
                            // empty the slot, then repair the cluster behind it
                            o_cmd.wr_val    = 1'b1;
                            o_cmd.scan_init = 1'b1;
                            n_state         = S_RRD;
                        end else begin
                            n_res   = RES_MISS;
                            n_state = S_FIN;
                        end
                    end else begin
                        o_cmd.keep_val = 1'b1;
                        n_res          = RES_LOOKUP;
                        n_state        = S_FIN;
                    end
                end else if (i_sts.cnt_last) begin
                    n_res   = RES_MISS;
                    n_state = S_FIN;
                end else begin
                    o_cmd.probe_next = 1'b1;
                    n_state          = S_PRD;
                end
            end
            S_RRD: begin
                if (i_sts.mcnt_full) begin
                    n_res   = RES_OK;
                    n_state = S_FIN;
                end else begin
                    o_cmd.rd_scan = 1'b1;
                    n_state       = S_RCK;
                end
            end
            S_RCK: begin
                if (i_sts.val_zero) begin
                    n_res   = RES_OK;
                    n_state = S_FIN;
                end else begin
                    o_cmd.rep_load   = 1'b1;
                    o_cmd.wr_val     = 1'b1;
                    o_cmd.wr_at_scan = 1'b1;
                    n_rep            = 1'b1;
                    n_state          = S_H0;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_rep   <= 1'b0;
            r_res   <= RES_MISS;
        end else begin
            r_state <= n_state;
            r_rep   <= n_rep;
            r_res   <= n_res;
        end
    end

`ifndef SYNTHESIS
    a_accept_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_H0))
        else $error("accepted item did not enter hashing");

    a_res_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.res_load |-> i_sts.out_free)
        else $error("result loaded over an untaken result");

    a_fin_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && !i_sts.out_free) |=> (r_state == S_FIN))
        else $error("result dropped while output stalled");

    a_key_wr_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wr_key |-> (!o_cmd.wr_at_scan && r_state == S_PCK))
        else $error("key written outside a probe check");
`endif

endmodule

// ----- hw/rtl/linear_probe_hash_map_top.sv -----
// Channel  Dir  Handshake                        Payload
// s_axis   in   i_s_axis_tvalid/o_s_axis_tready  kind, key, entry
// m_axis   out  o_m_axis_tvalid/i_m_axis_tready  status, found_entry
// cfg      in   i_cfg_we                         entry_limit
//
// One item at a time: accept, key hashing (mix, reciprocal multiply,
// remainder), a read and a check per probe of the slot store, then the
// result is loaded once the output register can take it.
// A remove that hits also walks the rest of the cluster, reading each slot
// and hashing and probing again for each slot reinserted.
// After reset the value store is cleared while items are held off.
// A stalled result sits in the output register; the next item is accepted
// and worked on, and waits only to load its own result.
module linear_probe_hash_map_top #(
    parameter int SLOT_COUNT = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // kind[1:0], key[17:2], entry[25:18]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // status[1:0], found_entry[9:2]
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata       // entry_limit
);
    import lhm_pkg::*;

    t_cmd                cmd;
    t_sts                sts;
    logic [STATUS_W-1:0] status;
    logic [ENTRY_W-1:0]  found;

    // sequencer: probe loop, cluster repair, clear sweep
    lhm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // hash pipe, slot store, pointers, output register
    lhm_dpath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_kind      (i_s_axis_tdata[1:0]),
        .i_key       (i_s_axis_tdata[17:2]),
        .i_entry     (i_s_axis_tdata[25:18]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_status    (status),
        .o_found     (found)
    );

    assign o_m_axis_tdata = {6'd0, found, status};

endmodule

// ----- tb/sv/linear_probe_hash_map_top_tb.sv -----
`timescale 1ns / 100ps

module linear_probe_hash_map_top_tb;
    import lhm_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int SLOTS          = 512;
    // Worst quiet stretch: a remove in a full table re-homes 511 slots,
    // the receiver hold-off of the random traffic test, the clearing pass.
    localparam int WATCHDOG_LIMIT = 50000;
    localparam int PHASE_ITEMS    = 150;
    localparam int POOL_SIZE      = 160;
    localparam int MAX_PRINTS     = 50;

    // kind 3 is not an operation; the block answers it with a miss
    localparam logic [KIND_W-1:0] OP_NONE = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ENTRY_W-1:0]  found;
    } map_result_t;

    // ------------------------------------------------------------------
    // DUT inputs, all driven to known values from time zero
    // ------------------------------------------------------------------
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    wire         o_s_axis_tready;
    logic [31:0] i_s_axis_tdata  = '0;   // kind[1:0], key[17:2], entry[25:18]
    wire         o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    wire  [15:0] o_m_axis_tdata;         // status[1:0], found_entry[9:2]
    logic        i_cfg_we        = 1'b0;
    logic [7:0]  i_cfg_wdata     = '0;   // entry_limit

    linear_probe_hash_map_top #(
        .SLOT_COUNT(SLOTS)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow copy of the map: slot keys, slot values (entry + 1, 0 = empty)
    // and the lookup limit. Updated when an item is accepted or the limit is set.
    // ------------------------------------------------------------------
    logic [KEY_W-1:0]   map_key [SLOTS] = '{default: '0};
    logic [ENTRY_W-1:0] map_val [SLOTS] = '{default: '0};
    logic [ENTRY_W-1:0] map_limit       = ENTRY_LIMIT_RST;

    map_result_t expected_q[$];   // results owed by the block, oldest first
    int          err_count   = 0;
    bit          steady      = 1'b0;  // no idling on either side
    int          hold_left   = 0;     // receiver hold-off, in cycles
    int          stall_cycles = 0;

    // xorshift mix of the key, reduced to a slot number
    function automatic int unsigned home_of(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] h;
        h = k ^ (k >> 7);
        h = h ^ {h[6:0], 9'b0};
        h = h ^ (h >> 8);
        return h % SLOTS;
    endfunction

    // first key at or after start whose home is the given slot
    function automatic logic [KEY_W-1:0] key_at_home(input int unsigned home,
                                                     input logic [KEY_W-1:0] start);
        logic [KEY_W-1:0] k;
        k = start;
        while (home_of(k) != home)
            k = k + 16'd1;
        return k;
    endfunction

    function automatic bit map_put(input logic [KEY_W-1:0] key, input logic [ENTRY_W-1:0] value);
        int unsigned s;
        s = home_of(key);
        for (int n = 0; n < SLOTS; n++) begin
            if (map_val[s] == '0 || map_key[s] == key) begin
                map_key[s] = key;
                map_val[s] = value;
                return 1'b1;
            end
            s = (s + 1) % SLOTS;
        end
        return 1'b0;
    endfunction

    // clear a matching slot, then re-home the rest of its cluster
    function automatic bit map_drop(input logic [KEY_W-1:0] key, input logic [ENTRY_W-1:0] value);
        int unsigned        s;
        int unsigned        scan;
        logic [KEY_W-1:0]   k;
        logic [ENTRY_W-1:0] v;
        s = home_of(key);
        for (int n = 0; n < SLOTS; n++) begin
            if (map_val[s] == '0)
                return 1'b0;
            if (map_key[s] == key) begin
                if (map_val[s] != value)
                    return 1'b0;
                map_val[s] = '0;
                scan = (s + 1) % SLOTS;
                for (int m = 0; m < SLOTS && map_val[scan] != '0; m++) begin
                    k = map_key[scan];
                    v = map_val[scan];
                    map_val[scan] = '0;
                    void'(map_put(k, v));
                    scan = (scan + 1) % SLOTS;
                end
                return 1'b1;
            end
            s = (s + 1) % SLOTS;
        end
        return 1'b0;
    endfunction

    // raw stored value for a key, 0 when absent
    function automatic logic [ENTRY_W-1:0] map_find(input logic [KEY_W-1:0] key);
        int unsigned s;
        s = home_of(key);
        for (int n = 0; n < SLOTS; n++) begin
            if (map_val[s] == '0)
                return '0;
            if (map_key[s] == key)
                return map_val[s];
            s = (s + 1) % SLOTS;
        end
        return '0;
    endfunction

    function automatic map_result_t apply_map_op(input logic [KIND_W-1:0] kind,
                                                 input logic [KEY_W-1:0] key,
                                                 input logic [ENTRY_W-1:0] entry);
        map_result_t        r;
        logic [ENTRY_W-1:0] v;
        r.status = ST_MISS;
        r.found  = '0;
        case (kind)
            OP_INSERT: begin
                if (entry != ENTRY_NONE)
                    r.status = map_put(key, entry + 8'd1) ? ST_OK : ST_FULL;
            end
            OP_REMOVE: begin
                if (entry != ENTRY_NONE && map_drop(key, entry + 8'd1))
                    r.status = ST_OK;
            end
            OP_LOOKUP: begin
                v = map_find(key);
                if (v != '0 && v <= map_limit) begin
                    r.status = ST_OK;
                    r.found  = v - 8'd1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (err_count < MAX_PRINTS)
            $display("%0t: mismatch: %s", $time, what);
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // Sender: random idle cycles, then hold the item until tready.
    // Handshakes are sampled at the falling edge, where inputs and
    // outputs are settled, and take effect at the next rising edge.
    // ------------------------------------------------------------------
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
                             input logic [ENTRY_W-1:0] entry);
        bit taken;
        while (!steady && $urandom_range(0, 99) < 37) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {6'd0, entry, key, kind};
        do begin
            @(negedge i_clk);
            taken = o_s_axis_tready;
            @(posedge i_clk);
        end while (!taken);
        expected_q.push_back(apply_map_op(kind, key, entry));
    endtask

    // every item gives one result, so an empty queue means the block is idle
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_limit(input logic [ENTRY_W-1:0] value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        map_limit = value;
    endtask

    // remove every live entry, walking slots up or down
    task automatic drain_map(input bit descending);
        int s;
        for (int i = 0; i < SLOTS; i++) begin
            s = descending ? SLOTS - 1 - i : i;
            while (map_val[s] != '0)
                send_item(OP_REMOVE, map_key[s], map_val[s] - 8'd1);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random tready, high when steady, low while a hold-off is running
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            i_m_axis_tready <= steady || ($urandom_range(0, 99) >= 37);
        end
    end

    // Result checker: compare each accepted result with the oldest one owed
    always begin : result_checker
        logic        taken;
        logic [15:0] data;
        map_result_t want;
        @(negedge i_clk);
        taken = o_m_axis_tvalid && i_m_axis_tready;
        data  = o_m_axis_tdata;
        @(posedge i_clk);
        if (taken === 1'b1) begin
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result %h with no item outstanding", data));
            end else begin
                want = expected_q.pop_front();
                if (data[1:0] !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              data[1:0], want.status));
                if (data[9:2] !== want.found)
                    report_mismatch($sformatf("found_entry %0d, want %0d",
                                              data[9:2], want.found));
            end
        end
    end

    // Watchdog: too long with no item moving on either side
    always @(negedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) === 1'b1 ||
            (o_m_axis_tvalid && i_m_axis_tready) === 1'b1)
            stall_cycles = 0;
        else
            stall_cycles = stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", stall_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, each operation, and the corner cases of insert,
    // remove and lookup, including a cluster that wraps past the last slot.
    task automatic test_basic_ops();
        logic [KEY_W-1:0] c0;
        logic [KEY_W-1:0] c1;
        logic [KEY_W-1:0] c2;
        c0 = key_at_home(SLOTS - 1, 16'($urandom));
        c1 = key_at_home(SLOTS - 1, c0 + 16'd1);
        c2 = key_at_home(SLOTS - 1, c1 + 16'd1);
        send_item(OP_LOOKUP, 16'h0000, 8'd0);      // empty map
        send_item(OP_INSERT, 16'h0000, 8'd0);
        send_item(OP_LOOKUP, 16'h0000, 8'd0);
        send_item(OP_INSERT, 16'hFFFF, 8'd254);    // largest storable entry
        send_item(OP_LOOKUP, 16'hFFFF, 8'hFF);     // stored 255 > limit: miss
        send_item(OP_INSERT, 16'h0000, 8'd159);    // overwrite in place
        send_item(OP_LOOKUP, 16'h0000, 8'd0);      // value equals limit: hit
        send_item(OP_INSERT, 16'h1234, ENTRY_NONE); // entry that cannot be stored
        send_item(OP_LOOKUP, 16'h1234, 8'd0);
        send_item(OP_REMOVE, 16'h0000, 8'd3);      // wrong entry, left alone
        send_item(OP_REMOVE, 16'h5555, 8'd1);      // absent key
        send_item(OP_REMOVE, 16'hFFFF, ENTRY_NONE);
        send_item(OP_NONE,   16'hFFFF, 8'hFF);
        // three keys on the last slot: the cluster wraps through slot 0
        send_item(OP_INSERT, c0, 8'd10);
        send_item(OP_INSERT, c1, 8'd11);
        send_item(OP_INSERT, c2, 8'd12);
        send_item(OP_REMOVE, c0, 8'd10);           // repair across the wrap
        send_item(OP_LOOKUP, c1, 8'd0);
        send_item(OP_LOOKUP, c2, 8'd0);
        send_item(OP_LOOKUP, c0, 8'd0);
        send_item(OP_REMOVE, 16'h0000, 8'd159);
        send_item(OP_LOOKUP, c2, 8'd0);
        send_item(OP_REMOVE, c1, 8'd11);
        send_item(OP_LOOKUP, c2, 8'd0);
    endtask

    task automatic test_entry_limit();
        set_limit(8'd255);
        send_item(OP_LOOKUP, 16'hFFFF, 8'd0);      // 255 now reads as entry 254
        set_limit(8'd1);
        send_item(OP_LOOKUP, 16'hFFFF, 8'd0);
        send_item(OP_INSERT, 16'h00A5, 8'd0);
        send_item(OP_LOOKUP, 16'h00A5, 8'd0);      // value 1, at the limit
        set_limit(ENTRY_LIMIT_RST);
    endtask

    // Mostly operations on a pool of keys, some of them crowded on a few
    // home slots, so that hits, clusters and repairs are common.
    task automatic test_random_traffic();
        logic [ENTRY_W-1:0] limits [5];
        logic [KEY_W-1:0]   pool [POOL_SIZE];
        logic [KEY_W-1:0]   k;
        logic [KEY_W-1:0]   pick;
        logic [ENTRY_W-1:0] v;
        int unsigned        home;
        int                 roll;
        limits[0] = 8'd255;
        limits[1] = 8'd1;
        limits[2] = 8'($urandom_range(2, 254));
        limits[3] = ENTRY_LIMIT_RST;
        limits[4] = 8'($urandom_range(1, 255));
        for (int i = 0; i < 100; i++)
            pool[i] = 16'($urandom);
        for (int g = 0; g < 10; g++) begin
            home = (g < 2) ? SLOTS - 1 - g : $urandom_range(0, SLOTS - 1);
            k = 16'($urandom);
            for (int j = 0; j < 6; j++) begin
                k = key_at_home(home, k);
                pool[100 + g * 6 + j] = k;
                k = k + 16'd1;
            end
        end
        for (int p = 0; p < 5; p++) begin
            set_limit(limits[p]);
            steady = (p == 2);
            // long receiver hold while items keep coming: the block fills up
            if (p == 1)
                hold_left = 400;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 2 && i == 100)
                    steady = 1'b0;
                pick = pool[$urandom_range(0, POOL_SIZE - 1)];
                roll = $urandom_range(0, 99);
                if (roll < 40) begin
                    send_item(OP_INSERT,
                              ($urandom_range(0, 9) == 0) ? 16'($urandom) : pick,
                              ($urandom_range(0, 29) == 0) ? ENTRY_NONE
                                                           : 8'($urandom_range(0, 254)));
                end else if (roll < 65) begin
                    // usually the right entry so removes actually land
                    v = map_find(pick);
                    send_item(OP_REMOVE, pick,
                              (v != '0 && $urandom_range(0, 3) != 0) ? v - 8'd1
                                                                     : 8'($urandom));
                end else if (roll < 95) begin
                    send_item(OP_LOOKUP,
                              ($urandom_range(0, 6) == 0) ? 16'($urandom) : pick,
                              8'($urandom));
                end else begin
                    send_item(OP_NONE, 16'($urandom), 8'($urandom));
                end
            end
        end
        steady = 1'b0;
    endtask

    // Fill every slot with a key at its own home, hit the full-table cases,
    // then empty it from the top so that only the first repair is long.
    task automatic test_full_table();
        logic [KEY_W-1:0] fill [SLOTS];
        logic [KEY_W-1:0] stranger;
        drain_map(1'b0);
        set_limit(8'd255);
        for (int s = 0; s < SLOTS; s++) begin
            fill[s] = key_at_home(s, 16'($urandom));
            send_item(OP_INSERT, fill[s], 8'($urandom_range(0, 254)));
        end
        stranger = key_at_home(0, fill[0] + 16'd1);
        send_item(OP_INSERT, stranger, 8'd7);      // no room left
        send_item(OP_LOOKUP, stranger, 8'd0);      // probes every slot
        send_item(OP_REMOVE, stranger, 8'd7);
        send_item(OP_INSERT, fill[100], 8'd42);    // overwrite still works
        send_item(OP_LOOKUP, fill[100], 8'd0);
        send_item(OP_LOOKUP, fill[SLOTS - 1], 8'd0);
        drain_map(1'b1);
        send_item(OP_LOOKUP, fill[100], 8'd0);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_basic_ops();
        test_entry_limit();
        test_random_traffic();
        test_full_table();
        wait_idle();
        repeat (40) @(posedge i_clk);
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
